FILE: rtl/core/tgr_pkg.sv
package tgr_pkg;

    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
    localparam int CLIP_CHARS = 255;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_MARKER = 8'h3E;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_PIXEL_SCALE = 2'd0;
    localparam logic [1:0] REG_FIT_MODE    = 2'd1;
    localparam logic [1:0] REG_WIDTH_LIMIT = 2'd2;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    // Command from the front end to the dot scanner.
    typedef struct packed {
        logic        start;
        glyph_t      glyph;
        logic [15:0] org_x;
        logic [15:0] org_y;
    } scan_cmd_t;

    // Top row lands in the highest bits, leftmost column first.
    function automatic glyph_t pack_rows(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6);
        pack_rows = {r0, r1, r2, r3, r4, r5, r6};
    endfunction

    // Every code without a glyph of its own falls to the boxed question mark.
    function automatic glyph_t glyph_bits(input logic [7:0] code);
        case (code)
            CHAR_SPACE: glyph_bits = '0;
            "0":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14);
            "1":  glyph_bits = pack_rows(5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            "2":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31);
            "3":  glyph_bits = pack_rows(5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30);
            "4":  glyph_bits = pack_rows(5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2);
            "5":  glyph_bits = pack_rows(5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14);
            "6":  glyph_bits = pack_rows(5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14);
            "7":  glyph_bits = pack_rows(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8);
            "8":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14);
            "9":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12);
            "A":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            "B":  glyph_bits = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30);
            "C":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14);
            "D":  glyph_bits = pack_rows(5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30);
            "E":  glyph_bits = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31);
            "F":  glyph_bits = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16);
            "G":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15);
            "H":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            "I":  glyph_bits = pack_rows(5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            "J":  glyph_bits = pack_rows(5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12);
            "K":  glyph_bits = pack_rows(5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17);
            "L":  glyph_bits = pack_rows(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31);
            "M":  glyph_bits = pack_rows(5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17);
            "N":  glyph_bits = pack_rows(5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17);
            "O":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            "P":  glyph_bits = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16);
            "Q":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13);
            "R":  glyph_bits = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17);
            "S":  glyph_bits = pack_rows(5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30);
            "T":  glyph_bits = pack_rows(5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4);
            "U":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            "V":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4);
            "W":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10);
            "X":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17);
            "Y":  glyph_bits = pack_rows(5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4);
            "Z":  glyph_bits = pack_rows(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31);
            "a":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd14, 5'd1,  5'd15, 5'd17, 5'd15);
            "b":  glyph_bits = pack_rows(5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd30);
            "c":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd14, 5'd16, 5'd16, 5'd17, 5'd14);
            "d":  glyph_bits = pack_rows(5'd1,  5'd1,  5'd15, 5'd17, 5'd17, 5'd17, 5'd15);
            "e":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd14, 5'd17, 5'd31, 5'd16, 5'd14);
            "f":  glyph_bits = pack_rows(5'd6,  5'd8,  5'd30, 5'd8,  5'd8,  5'd8,  5'd8);
            "g":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd15, 5'd17, 5'd15, 5'd1,  5'd14);
            "h":  glyph_bits = pack_rows(5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17);
            "i":  glyph_bits = pack_rows(5'd4,  5'd0,  5'd12, 5'd4,  5'd4,  5'd4,  5'd14);
            "j":  glyph_bits = pack_rows(5'd2,  5'd0,  5'd6,  5'd2,  5'd2,  5'd18, 5'd12);
            "k":  glyph_bits = pack_rows(5'd16, 5'd16, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18);
            "l":  glyph_bits = pack_rows(5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            "m":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd26, 5'd21, 5'd21, 5'd21, 5'd21);
            "n":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd30, 5'd17, 5'd17, 5'd17, 5'd17);
            "o":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd14, 5'd17, 5'd17, 5'd17, 5'd14);
            "p":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd30, 5'd17, 5'd30, 5'd16, 5'd16);
            "q":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd15, 5'd17, 5'd15, 5'd1,  5'd1);
            "r":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd22, 5'd25, 5'd16, 5'd16, 5'd16);
            "s":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd15, 5'd16, 5'd14, 5'd1,  5'd30);
            "t":  glyph_bits = pack_rows(5'd8,  5'd8,  5'd30, 5'd8,  5'd8,  5'd9,  5'd6);
            "u":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd17, 5'd17, 5'd17, 5'd19, 5'd13);
            "v":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd17, 5'd17, 5'd17, 5'd10, 5'd4);
            "w":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd17, 5'd17, 5'd21, 5'd21, 5'd10);
            "x":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd17, 5'd10, 5'd4,  5'd10, 5'd17);
            "y":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd17, 5'd17, 5'd15, 5'd1,  5'd14);
            "z":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd31, 5'd2,  5'd4,  5'd8,  5'd31);
            "?":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4);
            ".":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12);
            "/":  glyph_bits = pack_rows(5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16);
            "\\": glyph_bits = pack_rows(5'd16, 5'd16, 5'd8,  5'd4,  5'd2,  5'd1,  5'd1);
            "+":  glyph_bits = pack_rows(5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0);
            "-":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0);
            "_":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31);
            ":":  glyph_bits = pack_rows(5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0);
            "&":  glyph_bits = pack_rows(5'd12, 5'd18, 5'd20, 5'd8,  5'd21, 5'd18, 5'd13);
            "(":  glyph_bits = pack_rows(5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2);
            ")":  glyph_bits = pack_rows(5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8);
            "[":  glyph_bits = pack_rows(5'd14, 5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd14);
            "]":  glyph_bits = pack_rows(5'd14, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd14);
            "<":  glyph_bits = pack_rows(5'd2,  5'd4,  5'd8,  5'd16, 5'd8,  5'd4,  5'd2);
            ">":  glyph_bits = pack_rows(5'd8,  5'd4,  5'd2,  5'd1,  5'd2,  5'd4,  5'd8);
            "=":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0);
            ",":  glyph_bits = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd4,  5'd8);
            "@":  glyph_bits = pack_rows(5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14);
            "*":  glyph_bits = pack_rows(5'd0,  5'd21, 5'd14, 5'd31, 5'd14, 5'd21, 5'd0);
            default: glyph_bits = pack_rows(5'd31, 5'd17, 5'd5, 5'd2, 5'd4, 5'd0, 5'd4);
        endcase
    endfunction

endpackage

FILE: rtl/core/tgr_fitdiv.sv
module tgr_fitdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] width_limit,
    input  logic [6:0]  pixel_scale,
    output logic        busy,
    output logic [7:0]  fit
);
    import tgr_pkg::*;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'b01,
        DIV_RUN  = 2'b10
    } div_state_t;

    div_state_t  st_reg, st_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] dq_reg, dq_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  dvs_reg, dvs_next;
    logic [7:0]  fit_reg, fit_next;
    logic [10:0] shifted;
    logic [10:0] diff;
    logic        ge;
    logic [15:0] quot;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the top of dq_reg while quotient bits shift in at the bottom.
    // A start during a run begins again, so the count follows the latest write.
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[15]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        quot     = {dq_reg[14:0], ge};
        st_next  = st_reg;
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        fit_next = fit_reg;
        if (start)
        begin
            st_next  = DIV_RUN;
            cnt_next = '0;
            dq_next  = width_limit;
            rem_next = '0;
            dvs_next = {1'b0, pixel_scale, 2'b00} + {2'b00, pixel_scale, 1'b0};
        end
        else
        begin
            unique case (st_reg)
                DIV_IDLE:
                begin
                    st_next = DIV_IDLE;
                end
                DIV_RUN:
                begin
                    dq_next  = quot;
                    rem_next = ge ? diff[9:0] : shifted[9:0];
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        st_next  = DIV_IDLE;
                        fit_next = (quot > 16'(CLIP_CHARS)) ? 8'(CLIP_CHARS) : quot[7:0];
                    end
                end
                default:
                begin
                    st_next = DIV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= DIV_IDLE;
            cnt_reg <= '0;
            fit_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            fit_reg <= fit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = (st_reg == DIV_RUN);
    assign fit  = fit_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == DIV_IDLE && start) |=> (st_reg == DIV_RUN && cnt_reg == 4'd0))
        else $error("divider did not start");
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == DIV_RUN && cnt_reg == 4'd15 && !start) |=> st_reg == DIV_IDLE)
        else $error("divider ran past its last quotient bit");
    a_fit_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == DIV_RUN && cnt_reg == 4'd15) |=> fit_reg <= 8'(CLIP_CHARS))
        else $error("fitting count above cap");

endmodule

FILE: rtl/core/tgr_scan.sv
module tgr_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  tgr_pkg::scan_cmd_t cmd,
    input  logic [6:0]        pixel_scale,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       cell_x,
    output logic [15:0]       cell_y,
    output logic              last_of_char
);
    import tgr_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'b01,
        SCAN_RUN  = 2'b10
    } scan_state_t;

    localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);

    scan_state_t st_reg, st_next;
    glyph_t      vec_reg, vec_next;
    logic [2:0]  col_reg, col_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [15:0] base_x_reg, base_x_next;
    logic [15:0] step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] cell_x_reg, cell_x_next;
    logic [15:0] cell_y_reg, cell_y_next;
    logic        last_reg, last_next;
    logic        out_free;
    logic        advance;
    logic        dot;
    logic        rest_empty;

    // One glyph dot per cycle unless the output stalls: the dot under the cursor is
    // the top bit of the shift register, and it is the last cell once nothing is left below it.
    always_comb
    begin
        out_free    = !out_valid_reg || out_ready;
        advance     = (st_reg == SCAN_RUN) && out_free;
        dot         = vec_reg[GLYPH_BITS-1];
        rest_empty  = (vec_reg[GLYPH_BITS-2:0] == '0);
        st_next     = st_reg;
        vec_next    = vec_reg;
        col_next    = col_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        base_x_next = base_x_reg;
        step_next   = step_reg;
        cell_x_next = cell_x_reg;
        cell_y_next = cell_y_reg;
        last_next   = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (st_reg)
            SCAN_IDLE:
            begin
                if (cmd.start && cmd.glyph != '0)
                begin
                    st_next     = SCAN_RUN;
                    vec_next    = cmd.glyph;
                    col_next    = '0;
                    x_next      = cmd.org_x;
                    y_next      = cmd.org_y;
                    base_x_next = cmd.org_x;
                    step_next   = {9'd0, pixel_scale};
                end
            end
            SCAN_RUN:
            begin
                if (advance)
                begin
                    out_valid_next = dot;
                    if (dot)
                    begin
                        cell_x_next = x_reg;
                        cell_y_next = y_reg;
                        last_next   = rest_empty;
                    end
                    vec_next = {vec_reg[GLYPH_BITS-2:0], 1'b0};
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        x_next   = base_x_reg;
                        y_next   = y_reg + step_reg;
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                        x_next   = x_reg + step_reg;
                    end
                    if (rest_empty)
                    begin
                        st_next = SCAN_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = SCAN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= SCAN_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg    <= vec_next;
        col_reg    <= col_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        base_x_reg <= base_x_next;
        step_reg   <= step_next;
        cell_x_reg <= cell_x_next;
        cell_y_reg <= cell_y_next;
        last_reg   <= last_next;
    end

    assign busy         = (st_reg == SCAN_RUN);
    assign out_valid    = out_valid_reg;
    assign cell_x       = cell_x_reg;
    assign cell_y       = cell_y_reg;
    assign last_of_char = last_reg;

    a_run_has_dots: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == SCAN_RUN |-> vec_reg != '0)
        else $error("scanner running on an empty glyph");
    a_last_dot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && rest_empty) |=> (st_reg == SCAN_IDLE && out_valid_reg && last_reg))
        else $error("last dot did not close the character");
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SCAN_IDLE && cmd.start && cmd.glyph != '0) |=> st_reg == SCAN_RUN)
        else $error("scanner missed a start");

endmodule

FILE: rtl/core/text_glyph_rasterizer_5x7.sv
// Each drawn, non-blank character is scanned one glyph dot per cycle while the output
// is not stalled, top row first, and a cell leaves for every set dot; the scan stops
// after the last set dot. A drawn character holds s_tready low until its last set dot
// is scanned, plus output stalls; an undrawn or blank character does not hold it low.
// A cell is valid the cycle after its dot is scanned.
// Input waits after a register write until the fitting count is recomputed. Reset: async, active low.
module text_glyph_rasterizer_5x7 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // character_code, origin_x, origin_y, string_length
    input  logic        s_tuser,  // first_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // cell_x, cell_y
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tgr_pkg::*;

    logic [6:0]  pixel_scale_reg;
    logic        fit_mode_reg;
    logic [15:0] width_limit_reg;
    logic        cfg_wr_reg, cfg_wr_next;
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] row_top_y_reg, row_top_y_next;
    logic [7:0]  char_position_reg, char_position_next;

    logic        cfg_wr;
    logic        div_busy;
    logic [7:0]  fit;
    logic        scan_busy;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    scan_cmd_t   cmd;

    logic        accept;
    logic [7:0]  character_code;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  string_length;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic [7:0]  pos;
    logic        clipped;
    logic        drawn;
    logic        marker;
    logic [15:0] advance_w;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_scale_reg <= 7'd1;
            fit_mode_reg    <= 1'b0;
            width_limit_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PIXEL_SCALE: pixel_scale_reg <= pwdata[6:0];
                REG_FIT_MODE:    fit_mode_reg    <= pwdata[0];
                REG_WIDTH_LIMIT: width_limit_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PIXEL_SCALE: prdata = {25'd0, pixel_scale_reg};
            REG_FIT_MODE:    prdata = {31'd0, fit_mode_reg};
            REG_WIDTH_LIMIT: prdata = {16'd0, width_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // The divider starts the cycle after a write, once the register holds it.
    assign cfg_wr_next = cfg_wr;

    tgr_fitdiv u_fitdiv (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cfg_wr_reg),
        .width_limit (width_limit_reg),
        .pixel_scale (pixel_scale_reg),
        .busy        (div_busy),
        .fit         (fit)
    );

    assign s_tready = !scan_busy && !div_busy && !cfg_wr_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        character_code = s_tdata[7:0];
        origin_x       = s_tdata[23:8];
        origin_y       = s_tdata[39:24];
        string_length  = s_tdata[47:40];
        base_x = s_tuser ? origin_x : cursor_x_reg;
        base_y = s_tuser ? origin_y : row_top_y_reg;
        pos    = s_tuser ? 8'd0 : char_position_reg;
        char_position_next = (pos == 8'hFF) ? pos : pos + 8'd1;

        // In fit mode, a string at least as long as the fitting count keeps fit-1 characters
        // and shows the marker in the position after them; if fit is 1, none is drawn.
        clipped = (string_length >= fit);
        drawn   = (pixel_scale_reg != '0) &&
                  (!fit_mode_reg ||
                   ((fit != '0) && (!clipped || ((fit > 8'd1) && (pos < fit)))));
        marker  = fit_mode_reg && clipped && (pos == fit - 8'd1);

        advance_w = {7'd0, pixel_scale_reg, 2'b00} + {8'd0, pixel_scale_reg, 1'b0};
        cursor_x_next  = drawn ? base_x + advance_w : base_x;
        row_top_y_next = base_y;

        cmd.start = accept && drawn;
        cmd.glyph = glyph_bits(marker ? CHAR_MARKER : character_code);
        cmd.org_x = base_x;
        cmd.org_y = base_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_wr_reg        <= 1'b0;
            cursor_x_reg      <= '0;
            row_top_y_reg     <= '0;
            char_position_reg <= '0;
        end
        else
        begin
            cfg_wr_reg <= cfg_wr_next;
            if (accept)
            begin
                cursor_x_reg      <= cursor_x_next;
                row_top_y_reg     <= row_top_y_next;
                char_position_reg <= char_position_next;
            end
        end
    end

    tgr_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pixel_scale  (pixel_scale_reg),
        .busy         (scan_busy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .last_of_char (m_tlast)
    );

    assign m_tdata = {cell_y, cell_x};

    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !accept)
        else $error("item accepted while fitting count was stale");
    a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !s_tready)
        else $error("input open in the cycle after a register write");
    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && cmd.glyph != '0 |=> !s_tready)
        else $error("input open while a glyph is being scanned");

endmodule
